>>> hdl/lsdrs_pkg.sv
// Shared constants and types for the LSD radix sorter.
// No dependencies; lsdrs_chan_if and lsd_radix_sorter refer to it.
`default_nettype none

package lsdrs_pkg;

   localparam int DATA_W         = 16;
   localparam int MAX_ITEMS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 16;
   localparam int RADIX_DEF      = 10;

   typedef logic [DATA_W-1:0] data_type;

endpackage

`default_nettype wire

>>> hdl/lsdrs_chan_if.sv
// Request and response channel interfaces of the LSD radix sorter.
// Depends on lsdrs_pkg for the payload type.
`default_nettype none

interface lsdrs_req_if;
   logic                 valid;
   logic                 ready;
   lsdrs_pkg::data_type  value;
   logic                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface lsdrs_rsp_if;
   logic                 valid;
   logic                 ready;
   lsdrs_pkg::data_type  value_res;
   logic                 last_res;
   logic                 dropped;

   modport source (output valid, output value_res, output last_res, output dropped,
                   input ready);
   modport sink   (input valid, input value_res, input last_res, input dropped,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/lsdrs_store.sv
// Ping-pong entry stores A and B: one shared write port, one registered read.
// No package dependency.
`default_nettype none

module lsdrs_store #(
   parameter int DEPTH = 64,
   parameter int EW    = 36
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     wr_sel,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [EW-1:0]            wr_data,
   input  wire logic                     rd_sel,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [EW-1:0]            rd_data
);

   logic [EW-1:0] store_a_ff [DEPTH];
   logic [EW-1:0] store_b_ff [DEPTH];
   logic [EW-1:0] rd_a_ff;
   logic [EW-1:0] rd_b_ff;
   logic          rd_sel_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel) begin
         store_a_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_a_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_sel) begin
         store_b_ff[wr_addr] <= wr_data;
      end
      rd_b_ff <= store_b_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= rd_sel;
   end

   assign rd_data = rd_sel_ff ? rd_b_ff : rd_a_ff;

endmodule

`default_nettype wire

>>> hdl/lsdrs_digit.sv
// Two-stage digit extractor: quotient and remainder of a value by RADIX,
// via reciprocal multiply plus one correction step. No package dependency.
`default_nettype none

module lsdrs_digit #(
   parameter int VB    = 16,
   parameter int RADIX = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [VB-1:0]             in_value,
   input  wire logic [VB-1:0]             in_quot,
   output logic                           out_valid,
   output logic      [VB-1:0]             out_value,
   output logic      [VB-1:0]             out_quot,
   output logic      [$clog2(RADIX)-1:0]  out_digit
);

   localparam int DW = $clog2(RADIX);
   localparam int XW = VB + DW + 1;
   localparam logic [VB-1:0] RECIP = VB'((64'd1 << VB) / RADIX);

   logic            vld1_ff;
   logic [2*VB-1:0] prod1_ff;
   logic [VB-1:0]   quot1_ff;
   logic [VB-1:0]   value1_ff;

   logic [VB-1:0]   est;
   logic [XW-1:0]   est_r;
   logic [XW-1:0]   rem_full;
   logic [DW:0]     rem;
   logic            fix;
   logic [DW:0]     rem_fix;

   logic            vld2_ff;
   logic [VB-1:0]   value2_ff;
   logic [VB-1:0]   quot2_ff;
   logic [DW-1:0]   digit2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff  <= (2*VB)'(in_quot) * (2*VB)'(RECIP);
      quot1_ff  <= in_quot;
      value1_ff <= in_value;
   end

   // estimate is the true quotient or one below it
   assign est      = prod1_ff[2*VB-1:VB];
   assign est_r    = XW'(est) * XW'(RADIX);
   assign rem_full = XW'(quot1_ff) - est_r;
   assign rem      = rem_full[DW:0];
   assign fix      = rem >= (DW+1)'(RADIX);
   assign rem_fix  = fix ? rem - (DW+1)'(RADIX) : rem;

   always_ff @(posedge clock) begin
      value2_ff <= value1_ff;
      quot2_ff  <= fix ? est + VB'(1) : est;
      digit2_ff <= rem_fix[DW-1:0];
   end

   assign out_valid = vld2_ff;
   assign out_value = value2_ff;
   assign out_quot  = quot2_ff;
   assign out_digit = digit2_ff;

endmodule

`default_nettype wire

>>> hdl/lsd_radix_sorter.sv
// LSD radix sorter top level: load, digit passes over stores A/B, emission.
// Depends on lsdrs_pkg, lsdrs_chan_if, lsdrs_store and lsdrs_digit.
// Requests load at one per cycle while the sorter is in its load state. After the
// last one, each pass over n items is a count sweep through the digit unit, a
// prefix sweep over the buckets and a scatter sweep; one pass per digit of the
// maximum, none if it is zero. Emission makes one read of the store per response
// and issues no read while one is in flight or a response waits on the sink. Reset
// is synchronous: control clears, stores are not cleared and need no clearing pass.
`default_nettype none

module lsd_radix_sorter #(
   parameter int MAX_ITEMS  = lsdrs_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = lsdrs_pkg::VALUE_BITS_DEF,
   parameter int RADIX      = lsdrs_pkg::RADIX_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   lsdrs_req_if.sink    req_if,
   lsdrs_rsp_if.source  rsp_if
);

   localparam int VB = VALUE_BITS;
   localparam int DP = lsdrs_pkg::DATA_W;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int DW = $clog2(RADIX);
   localparam int EW = 2 * VB + DW;

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_COUNT  = 3'd1;
   localparam logic [2:0] ST_PREFIX = 3'd2;
   localparam logic [2:0] ST_DIST   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] item_cnt_ff;
   logic          any_nz_ff;
   logic          drop_ff;
   logic          src_ff;
   logic          more_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] wb_ff;
   logic          rv_ff;
   logic          fetch_ff;
   logic          last_pend_ff;
   logic [DW-1:0] k_ff;
   logic [CW-1:0] sum_ff;
   logic [CW-1:0] cnt_ff [RADIX];

   logic          rsp_valid_ff;
   logic [DP-1:0] rsp_value_ff;
   logic          rsp_last_ff;
   logic          rsp_drop_ff;

   logic             acc, full, store_en, in_nz, start_sort;
   logic [VB+DP-1:0] in_ext;
   logic [VB-1:0]    in_v;
   logic             sweep_issue, emit_issue, rd_issue;
   logic             count_done, prefix_done, dist_done, state_chg;

   logic             wr_en, wr_sel;
   logic [AW-1:0]    wr_addr;
   logic [EW-1:0]    wr_data;
   logic [EW-1:0]    rd_data;
   logic [VB-1:0]    rd_v;
   logic [DW-1:0]    rd_d;
   logic [VB+DP-1:0] rd_ext;

   logic             dg_valid;
   logic [VB-1:0]    dg_value, dg_quot;
   logic [DW-1:0]    dg_digit;

   assign acc        = req_if.valid && req_if.ready;
   assign full       = item_cnt_ff == CW'(MAX_ITEMS);
   assign store_en   = acc && !full;
   assign in_ext     = (VB+DP)'(req_if.value);
   assign in_v       = in_ext[VB-1:0];
   assign in_nz      = |in_v;
   assign start_sort = acc && req_if.last;

   assign sweep_issue = (state_ff == ST_COUNT || state_ff == ST_DIST) &&
                        (idx_ff < item_cnt_ff);
   assign emit_issue  = (state_ff == ST_EMIT) && (idx_ff < item_cnt_ff) && !fetch_ff &&
                        (!rsp_valid_ff || rsp_if.ready);
   assign rd_issue    = sweep_issue || emit_issue;

   assign count_done  = (state_ff == ST_COUNT) && (wb_ff == item_cnt_ff);
   assign prefix_done = (state_ff == ST_PREFIX) && (k_ff == DW'(RADIX - 1));
   assign dist_done   = (state_ff == ST_DIST) && (wb_ff == item_cnt_ff);

   assign rd_v   = rd_data[EW-1 -: VB];
   assign rd_d   = rd_data[DW-1:0];
   assign rd_ext = (VB+DP)'(rd_v);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (start_sort) begin
               state_in = (any_nz_ff || (store_en && in_nz)) ? ST_COUNT : ST_EMIT;
            end
         end
         ST_COUNT: begin
            if (count_done) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (prefix_done) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (dist_done) begin
               state_in = more_ff ? ST_COUNT : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (fetch_ff && last_pend_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign state_chg = state_in != state_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_sel  = 1'b0;
      wr_addr = item_cnt_ff[AW-1:0];
      wr_data = {in_v, in_v, DW'(0)};
      unique case (state_ff)
         ST_LOAD: begin
            wr_en = store_en;
         end
         ST_COUNT: begin
            wr_en   = dg_valid;
            wr_sel  = src_ff;
            wr_addr = wb_ff[AW-1:0];
            wr_data = {dg_value, dg_quot, dg_digit};
         end
         ST_DIST: begin
            wr_en   = rv_ff;
            wr_sel  = !src_ff;
            wr_addr = cnt_ff[rd_d][AW-1:0];
            wr_data = rd_data;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   lsdrs_store #(
      .DEPTH (MAX_ITEMS),
      .EW    (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_sel  (wr_sel),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_sel  (src_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   lsdrs_digit #(
      .VB    (VB),
      .RADIX (RADIX)
   ) u_digit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rv_ff && (state_ff == ST_COUNT)),
      .in_value  (rd_v),
      .in_quot   (rd_data[VB+DW-1:DW]),
      .out_valid (dg_valid),
      .out_value (dg_value),
      .out_quot  (dg_quot),
      .out_digit (dg_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         item_cnt_ff  <= '0;
         any_nz_ff    <= 1'b0;
         drop_ff      <= 1'b0;
         src_ff       <= 1'b0;
         more_ff      <= 1'b0;
         idx_ff       <= '0;
         wb_ff        <= '0;
         rv_ff        <= 1'b0;
         fetch_ff     <= 1'b0;
         last_pend_ff <= 1'b0;
         k_ff         <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= sweep_issue;
         fetch_ff     <= emit_issue;
         last_pend_ff <= idx_ff == item_cnt_ff - CW'(1);

         if (state_ff == ST_LOAD) begin
            if (store_en) begin
               item_cnt_ff <= item_cnt_ff + CW'(1);
               any_nz_ff   <= any_nz_ff || in_nz;
            end
            if (acc && full) begin
               drop_ff <= 1'b1;
            end
         end

         if (state_chg) begin
            idx_ff <= '0;
            wb_ff  <= '0;
         end else begin
            if (rd_issue) begin
               idx_ff <= idx_ff + CW'(1);
            end
            if ((state_ff == ST_COUNT && dg_valid) || (state_ff == ST_DIST && rv_ff)) begin
               wb_ff <= wb_ff + CW'(1);
            end
         end

         if (state_in == ST_COUNT && state_chg) begin
            more_ff <= 1'b0;
         end else if (state_ff == ST_COUNT && dg_valid && (|dg_quot)) begin
            more_ff <= 1'b1;
         end

         if (state_in == ST_PREFIX && state_chg) begin
            k_ff   <= '0;
            sum_ff <= '0;
         end else if (state_ff == ST_PREFIX) begin
            k_ff   <= k_ff + DW'(1);
            sum_ff <= sum_ff + cnt_ff[k_ff];
         end

         if (dist_done) begin
            src_ff <= !src_ff;
         end

         if (state_ff == ST_EMIT && state_in == ST_LOAD) begin
            item_cnt_ff <= '0;
            any_nz_ff   <= 1'b0;
            drop_ff     <= 1'b0;
            src_ff      <= 1'b0;
         end
      end
   end

   // bucket counts, turned into running start positions by the prefix sweep
   always_ff @(posedge clock) begin
      if (reset || (state_in == ST_COUNT && state_chg)) begin
         for (int i = 0; i < RADIX; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_COUNT: begin
               if (dg_valid) begin
                  cnt_ff[dg_digit] <= cnt_ff[dg_digit] + CW'(1);
               end
            end
            ST_PREFIX: begin
               cnt_ff[k_ff] <= sum_ff;
            end
            ST_DIST: begin
               if (rv_ff) begin
                  cnt_ff[rd_d] <= cnt_ff[rd_d] + CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fetch_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_ff) begin
         rsp_value_ff <= rd_ext[DP-1:0];
         rsp_last_ff  <= last_pend_ff;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign req_if.ready     = state_ff == ST_LOAD;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.value_res = rsp_value_ff;
   assign rsp_if.last_res  = rsp_last_ff;
   assign rsp_if.dropped   = rsp_drop_ff;

endmodule

`default_nettype wire
